/* rtl/core/signed_decimal_display_formatter_macros.svh */
// Assertion helpers for the display formatter.
`ifndef SIGNED_DECIMAL_DISPLAY_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_DISPLAY_FORMATTER_MACROS_SVH

// Check a property on every clock edge once out of reset.
`define SDDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SDDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/sddf_pkg.sv */
package sddf_pkg;

  localparam int ValueW = 16;
  localparam int MagW   = 14;
  localparam int PairW  = 7;
  localparam int CodeW  = 4;
  localparam int AddrW  = 3;
  localparam int PosW   = 2;
  localparam int NdigW  = 3;

  localparam logic [CodeW-1:0] CODE_BLANK = 4'd15;
  localparam logic [CodeW-1:0] CODE_MINUS = 4'd10;

  localparam logic [PosW-1:0] POS_LAST = 2'd3;

  // Range limits of what the display can show.
  localparam logic signed [ValueW-1:0] POS_MAX = 16'sd9999;
  localparam logic signed [ValueW-1:0] NEG_MIN = -16'sd999;

  // floor(m / 100) = (m * DIV100_MUL) >> DIV100_SHIFT, exact for m < 2**14
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x < 128
  localparam logic [7:0]  DIV10_MUL    = 8'd205;
  localparam int          DIV10_SHIFT  = 11;

  // Number split into two base-100 halves plus display flags.
  typedef struct packed {
    logic             show;
    logic             neg;
    logic [NdigW-1:0] ndig;
    logic [PairW-1:0] hi;   // thousands and hundreds
    logic [PairW-1:0] lo;   // tens and ones
  } split_t;

endpackage

/* rtl/core/sddf_split.sv */
module sddf_split (
  input  logic signed [sddf_pkg::ValueW-1:0] value,
  output sddf_pkg::split_t                   split
);

  logic                        in_pos;
  logic                        in_neg;
  logic [sddf_pkg::ValueW-1:0] negated;
  logic [sddf_pkg::MagW-1:0]   mag;
  logic [26:0]                 prod;
  logic [sddf_pkg::PairW-1:0]  hi;
  logic [sddf_pkg::MagW-1:0]   hi_x100;
  logic [sddf_pkg::MagW-1:0]   lo_full;

  assign in_pos  = (value >= 16'sd1) && (value <= sddf_pkg::POS_MAX);
  assign in_neg  = (value <= -16'sd1) && (value >= sddf_pkg::NEG_MIN);
  assign negated = 16'(-value);
  assign mag     = in_neg ? negated[sddf_pkg::MagW-1:0] : value[sddf_pkg::MagW-1:0];

  // Divide by 100 through a reciprocal multiply.
  assign prod    = 27'(mag) * 27'(sddf_pkg::DIV100_MUL);
  assign hi      = prod[sddf_pkg::DIV100_SHIFT +: sddf_pkg::PairW];
  assign hi_x100 = (14'(hi) << 6) + (14'(hi) << 5) + (14'(hi) << 2);
  assign lo_full = mag - hi_x100;

  always_comb begin
    split.show = in_pos || in_neg;
    split.neg  = in_neg;
    split.hi   = hi;
    split.lo   = lo_full[sddf_pkg::PairW-1:0];
    priority if (mag > 14'd999) begin
      split.ndig = 3'd4;
    end else if (mag > 14'd99) begin
      split.ndig = 3'd3;
    end else if (mag > 14'd9) begin
      split.ndig = 3'd2;
    end else begin
      split.ndig = 3'd1;
    end
  end

endmodule

/* rtl/core/sddf_digit.sv */
module sddf_digit (
  input  sddf_pkg::split_t             split,
  input  logic [sddf_pkg::PosW-1:0]    pos,
  output logic [sddf_pkg::AddrW-1:0]   addr,
  output logic [sddf_pkg::CodeW-1:0]   code
);

  logic [sddf_pkg::PairW-1:0] pair;
  logic [14:0]                prod;
  logic [sddf_pkg::CodeW-1:0] tens;
  logic [sddf_pkg::PairW-1:0] tens_x10;
  logic [sddf_pkg::PairW-1:0] ones_full;
  logic [sddf_pkg::CodeW-1:0] digit;

  // Upper two positions come from the high half.
  assign pair      = pos[1] ? split.hi : split.lo;
  assign prod      = 15'(pair) * 15'(sddf_pkg::DIV10_MUL);
  assign tens      = prod[sddf_pkg::DIV10_SHIFT +: sddf_pkg::CodeW];
  assign tens_x10  = (7'(tens) << 3) + (7'(tens) << 1);
  assign ones_full = pair - tens_x10;
  assign digit     = pos[0] ? tens : ones_full[sddf_pkg::CodeW-1:0];
  assign addr      = 3'(pos) + 3'd1;

  always_comb begin
    code = sddf_pkg::CODE_BLANK;
    if (split.show) begin
      if (addr <= split.ndig) begin
        code = digit;
      end else if (split.neg && (addr == split.ndig + 3'd1)) begin
        code = sddf_pkg::CODE_MINUS;
      end
    end
  end

endmodule

/* rtl/core/signed_decimal_display_formatter.sv */
// Signed decimal formatter for a four-digit code-B display driver.
// Input channel: in_value (signed 16 bits) with in_valid / in_ready.
// Result channel: four beats per value, out_digit_address 1 (rightmost)
// to 4 (leftmost), out_digit_code (0-9 digit, 10 minus, 15 blank), and
// out_last high on the address-4 beat.
// 1..9999 shows right-aligned with leading blanks; -1..-999 adds a minus
// just left of the leading digit; zero and anything else show all blank.
// An accepted value is held in the input register, then moves into the
// result register, from which its first beat shows.
// Each value takes four beats on the single result channel; the input
// register takes the next value while the current one is still draining.
// Reset (rst_n low, synchronous) drops both the input and result registers;
// no beat is in flight afterwards.
// A receiver stall holds the current beat steady; once the input register
// is full too, in_ready drops until the last beat of the draining value.
`include "signed_decimal_display_formatter_macros.svh"

module signed_decimal_display_formatter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sddf_pkg::ValueW-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sddf_pkg::AddrW-1:0]           out_digit_address,
  output logic [sddf_pkg::CodeW-1:0]           out_digit_code,
  output logic                                 out_last
);

  // Input register
  logic                                in_v_r;
  logic                                in_v_nxt;
  logic signed [sddf_pkg::ValueW-1:0]  value_r;

  // Result register: split number and the beat position inside it
  logic                                res_v_r;
  logic                                res_v_nxt;
  sddf_pkg::split_t                    split_r;
  sddf_pkg::split_t                    split_nxt;
  logic [sddf_pkg::PosW-1:0]           pos_r;
  logic [sddf_pkg::PosW-1:0]           pos_nxt;

  logic in_fire;
  logic out_fire;
  logic load;

  assign out_fire = out_valid && out_ready;
  assign out_last = (pos_r == sddf_pkg::POS_LAST);
  assign out_valid = res_v_r;

  // Move the held value forward when the result register is empty or
  // its last beat leaves this cycle.
  assign load     = in_v_r && (!res_v_r || (out_fire && out_last));
  assign in_ready = !in_v_r || load;
  assign in_fire  = in_valid && in_ready;

  sddf_split u_split (
    .value (value_r),
    .split (split_nxt)
  );

  sddf_digit u_digit (
    .split (split_r),
    .pos   (pos_r),
    .addr  (out_digit_address),
    .code  (out_digit_code)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    res_v_nxt = res_v_r;
    pos_nxt   = pos_r;
    if (load) begin
      res_v_nxt = 1'b1;
      pos_nxt   = '0;
    end else if (out_fire) begin
      if (out_last) begin
        res_v_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      res_v_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      res_v_r <= res_v_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Payload registers: capture only, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_r <= in_value;
    end
    if (load) begin
      split_r <= split_nxt;
    end
  end

  // Never overwrite a value that still has beats to deliver.
  `SDDF_ASSERT(a_load_free, load |-> (!res_v_r || out_last), "result register overwritten")
  // Advance one position per accepted non-final beat.
  `SDDF_ASSERT(a_pos_step, (out_fire && !out_last && !load) |=> (pos_r == 2'($past(pos_r) + 2'd1)), "beat position skipped")
  // Drain fully after the last beat when nothing is waiting.
  `SDDF_ASSERT(a_drain, (out_fire && out_last && !load) |=> !res_v_r, "result register not drained")
  // A minus sign only ever belongs to a negative number.
  `SDDF_ASSERT(a_minus_neg, (out_valid && (out_digit_code == sddf_pkg::CODE_MINUS)) |-> split_r.neg, "minus on non-negative value")

endmodule

/* bench/tb_signed_decimal_display_formatter.sv */
`timescale 1ns / 100ps

module tb_signed_decimal_display_formatter;

  // Watchdog bound, far above the slowest legal run of about 150 values.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_VALUES = 125;
  localparam int DIRECTED_ROWS = 25;

  // One directed row: the value, whether its digit codes are typed in, and
  // the codes packed with address 4 in the top nibble and address 1 at the bottom.
  typedef struct packed {
    logic signed [sddf_pkg::ValueW-1:0] value;
    logic                               typed;
    logic [4*sddf_pkg::CodeW-1:0]       codes;
  } stim_row_t;

  // One beat on the result channel.
  typedef struct packed {
    logic [sddf_pkg::AddrW-1:0] addr;
    logic [sddf_pkg::CodeW-1:0] code;
    logic                       last;
  } digit_word_t;

  localparam logic [4*sddf_pkg::CodeW-1:0] ALL_BLANK = {4{sddf_pkg::CODE_BLANK}};

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Zero, the range edges and the field extremes, typed in.
    '{16'sd0,      1'b1, ALL_BLANK},
    '{16'sd9999,   1'b1, {4'd9, 4'd9, 4'd9, 4'd9}},
    '{16'sd10000,  1'b1, ALL_BLANK},
    '{16'sd32767,  1'b1, ALL_BLANK},
    '{-16'sd32768, 1'b1, ALL_BLANK},
    '{-16'sd999,   1'b1, {sddf_pkg::CODE_MINUS, 4'd9, 4'd9, 4'd9}},
    '{-16'sd1000,  1'b1, ALL_BLANK},
    '{16'sd1,      1'b1, {sddf_pkg::CODE_BLANK, sddf_pkg::CODE_BLANK,
                          sddf_pkg::CODE_BLANK, 4'd1}},
    '{-16'sd1,     1'b1, {sddf_pkg::CODE_BLANK, sddf_pkg::CODE_BLANK,
                          sddf_pkg::CODE_MINUS, 4'd1}},
    // Digit-count boundaries, inner zeros and alternating bit patterns.
    '{16'sd9,      1'b0, '0},
    '{16'sd10,     1'b0, '0},
    '{16'sd99,     1'b0, '0},
    '{16'sd100,    1'b0, '0},
    '{16'sd999,    1'b0, '0},
    '{16'sd1000,   1'b0, '0},
    '{16'sd1001,   1'b0, '0},
    '{16'sd1010,   1'b0, '0},
    '{-16'sd9,     1'b0, '0},
    '{-16'sd10,    1'b0, '0},
    '{-16'sd99,    1'b0, '0},
    '{-16'sd100,   1'b0, '0},
    '{-16'sd101,   1'b0, '0},
    '{-16'sd1001,  1'b0, '0},
    '{16'sd21845,  1'b0, '0},
    '{-16'sd21846, 1'b0, '0}
  };

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [sddf_pkg::ValueW-1:0] in_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [sddf_pkg::AddrW-1:0]         out_digit_address;
  logic [sddf_pkg::CodeW-1:0]         out_digit_code;
  logic                               out_last;

  digit_word_t pending_words[$];
  int          error_count = 0;
  int          cycle_count = 0;
  // While set, neither side idles.
  logic        steady_flow = 1'b0;

  signed_decimal_display_formatter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digit_address (out_digit_address),
    .out_digit_code    (out_digit_code),
    .out_last          (out_last)
  );

  always #2 clk = ~clk;

  // Compute the four code-B nibbles for a value, address 1 in the low nibble.
  function automatic logic [4*sddf_pkg::CodeW-1:0] format_digits(
      input logic signed [sddf_pkg::ValueW-1:0] v);
    logic                         shown;
    logic                         negative;
    int                           mag;
    int                           ndig;
    int                           rest;
    logic [4*sddf_pkg::CodeW-1:0] codes;
    shown    = (v >= 1 && v <= sddf_pkg::POS_MAX) || (v <= -1 && v >= sddf_pkg::NEG_MIN);
    negative = v < 0;
    mag      = negative ? -int'(v) : int'(v);
    ndig     = (mag > 999) ? 4 : (mag > 99) ? 3 : (mag > 9) ? 2 : 1;
    rest     = mag;
    for (int p = 0; p < 4; p++) begin
      codes[p*sddf_pkg::CodeW +: sddf_pkg::CodeW] = sddf_pkg::CODE_BLANK;
      if (shown) begin
        // Show inner zeros as digits; put the minus just left of the leading digit.
        if (p < ndig) begin
          codes[p*sddf_pkg::CodeW +: sddf_pkg::CodeW] = sddf_pkg::CodeW'(rest % 10);
        end else if (negative && p == ndig) begin
          codes[p*sddf_pkg::CodeW +: sddf_pkg::CodeW] = sddf_pkg::CODE_MINUS;
        end
      end
      rest = rest / 10;
    end
    return codes;
  endfunction

  // Draw a value, mostly inside the displayable ranges, spread over digit counts.
  function automatic logic signed [sddf_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return sddf_pkg::ValueW'($urandom);
      1: return '0;
      2: return sddf_pkg::ValueW'($urandom_range(1, 9));
      3: return sddf_pkg::ValueW'($urandom_range(10, 99));
      4: return sddf_pkg::ValueW'($urandom_range(100, 999));
      5: return sddf_pkg::ValueW'($urandom_range(1000, 9999));
      6: return sddf_pkg::ValueW'(-int'($urandom_range(1, 9)));
      7: return sddf_pkg::ValueW'(-int'($urandom_range(10, 99)));
      8: return sddf_pkg::ValueW'(-int'($urandom_range(100, 999)));
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return sddf_pkg::ValueW'($urandom_range(10000, 32767));
        end else begin
          return sddf_pkg::ValueW'(-int'($urandom_range(1000, 32768)));
        end
      end
    endcase
  endfunction

  // Offer one value, hold it until accepted, then queue its four digit beats.
  task automatic drive_value(input logic signed [sddf_pkg::ValueW-1:0] v,
                             input logic typed,
                             input logic [4*sddf_pkg::CodeW-1:0] typed_codes);
    int                           gap;
    logic [4*sddf_pkg::CodeW-1:0] codes;
    gap = (!steady_flow && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    codes = typed ? typed_codes : format_digits(v);
    for (int p = 0; p < 4; p++) begin
      pending_words.push_back('{sddf_pkg::AddrW'(p + 1),
                                codes[p*sddf_pkg::CodeW +: sddf_pkg::CodeW],
                                p == sddf_pkg::POS_LAST});
    end
  endtask

  // Receiver: compare each beat with the oldest queued word, then pick the
  // next ready at random, or hold it high during steady flow.
  always @(posedge clk) begin : check_beat
    digit_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected beat addr %0d code %0d last %0b", $time,
                 out_digit_address, out_digit_code, out_last);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_digit_address !== want.addr) begin
          $display("%0t: digit_address expected %0d actual %0d", $time,
                   want.addr, out_digit_address);
          error_count++;
        end
        if (out_digit_code !== want.code) begin
          $display("%0t: digit_code at addr %0d expected %0d actual %0d", $time,
                   want.addr, want.code, out_digit_code);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last at addr %0d expected %0b actual %0b", $time,
                   want.addr, want.last, out_last);
          error_count++;
        end
      end
    end
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 33);
  end

  // Watchdog: stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    // Hold reset low, then release it at an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      drive_value(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].codes);
    end

    // Random values, with a stretch in the middle where nobody idles.
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == 50) steady_flow <= 1'b1;
      if (i == 90) steady_flow <= 1'b0;
      drive_value(pick_value(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then wait on for any stray beat to show up.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
